@@ hdl/pxp_pkg.sv @@
// Shared types and constants for the Paxos proposer vote tracker.
// No dependencies; imported by every module of the block.
package pxp_pkg;

	localparam int SerialW  = 32;
	localparam int ValueW   = 32;
	localparam int CountW   = 8;
	localparam int CfgW     = 8;
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;

	// Register index as decoded from paddr[2]
	localparam logic REG_PROPOSER_COUNT = 1'b0;
	localparam logic REG_ACCEPTOR_COUNT = 1'b1;

	localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};
	localparam logic [SerialW-1:0] SerialMax = {SerialW{1'b1}};

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PHASE1 = 2'd1,
		OP_PHASE2 = 2'd2
	} opcode_t;

	// One input item
	typedef struct packed {
		logic [1:0]         opcode;
		logic               ok;
		logic [SerialW-1:0] reply_serial;
		logic [ValueW-1:0]  reply_value;
		logic [SerialW-1:0] start_serial;
		logic [ValueW-1:0]  start_value;
	} item_t;

	// Proposer round state
	typedef struct packed {
		logic               phase_done;
		logic               agree_flag;
		logic [SerialW-1:0] max_seen_serial;
		logic [CountW-1:0]  promise_count;
		logic [CountW-1:0]  refusal_count;
		logic [SerialW-1:0] prop_serial;
		logic [ValueW-1:0]  prop_value;
	} round_t;

	// Configuration seen by the update logic
	typedef struct packed {
		logic [CfgW-1:0] proposer_count;
		logic [CfgW-1:0] acceptor_count;
	} cfg_t;

endpackage

@@ hdl/pxp_round_update.sv @@
// Next-state logic of one proposer round for one reply or start item.
// Depends on pxp_pkg.
module pxp_round_update import pxp_pkg::*; (
	input  round_t cur,
	input  cfg_t   cfg,
	input  item_t  item,
	output round_t nxt,
	output logic   going
);

	logic [CountW-1:0]  half;
	logic [CountW-1:0]  promise_inc;
	logic [CountW-1:0]  refusal_inc;
	logic               promise_maj;
	logic               refusal_maj;
	logic [SerialW:0]   serial_sum;
	logic [SerialW-1:0] serial_bumped;
	round_t             restart;

	// Saturating counters and majority tests
	always_comb begin
		half        = cfg.acceptor_count >> 1;
		promise_inc = (cur.promise_count == CountMax) ? cur.promise_count
		              : cur.promise_count + CountW'(1);
		refusal_inc = (cur.refusal_count == CountMax) ? cur.refusal_count
		              : cur.refusal_count + CountW'(1);
		promise_maj = promise_inc > half;
		refusal_maj = refusal_inc > half;
	end

	// Advance the serial by the proposer count, clamp on carry out
	always_comb begin
		serial_sum    = {1'b0, cur.prop_serial} + {{(SerialW+1-CfgW){1'b0}}, cfg.proposer_count};
		serial_bumped = serial_sum[SerialW] ? SerialMax : serial_sum[SerialW-1:0];
		restart             = '0;
		restart.prop_serial = serial_bumped;
		restart.prop_value  = cur.prop_value;
	end

	// Apply the item
	always_comb begin
		nxt   = cur;
		going = 1'b1;
		case (opcode_t'(item.opcode))
			OP_START: begin
				nxt             = '0;
				nxt.prop_serial = item.start_serial;
				nxt.prop_value  = item.start_value;
			end
			OP_PHASE1: begin
				if (!cur.phase_done) begin
					if (!item.ok) begin
						if (refusal_maj) begin
							nxt   = restart;
							going = 1'b0;
						end else begin
							nxt.refusal_count = refusal_inc;
						end
					end else begin
						nxt.promise_count = promise_inc;
						if (item.reply_serial > cur.max_seen_serial) begin
							nxt.max_seen_serial = item.reply_serial;
							nxt.prop_value      = item.reply_value;
						end
						if (promise_maj) begin
							nxt.promise_count = '0;
							nxt.phase_done    = 1'b1;
						end
					end
				end
			end
			OP_PHASE2: begin
				if (cur.phase_done) begin
					if (!item.ok) begin
						if (refusal_maj) begin
							nxt   = restart;
							going = 1'b0;
						end else begin
							nxt.refusal_count = refusal_inc;
						end
					end else begin
						nxt.promise_count = promise_inc;
						if (promise_maj) begin
							nxt.agree_flag = 1'b1;
						end
					end
				end
			end
			default: begin
				// unused opcode: hold state
				nxt = cur;
			end
		endcase
	end

endmodule

@@ hdl/paxos_proposer_vote_tracker.sv @@
// Top level of the Paxos proposer vote tracker: input stage, round state,
// result register and APB configuration registers. Depends on pxp_pkg, pxp_round_update.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | opcode, ok, reply_*, start_*
//  out     | from block| out_valid/out_stall| keep_going, accept_phase, agreed, cur_*
//  apb     | to block  | psel/penable/pready| paddr, pwdata, prdata
//
// One item per cycle unless the result stalls; each item passes through the
// input register, then one compare/add pass into the result register.
// The round state updates when an item leaves the input register, so the
// next item always sees it. A stalled result holds the input register; the
// input side stalls only while both registers are full.
// Reset clears the round state and both configuration registers.
module paxos_proposer_vote_tracker import pxp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic                ok,
	input  logic [SerialW-1:0]  reply_serial,
	input  logic [ValueW-1:0]   reply_value,
	input  logic [SerialW-1:0]  start_serial,
	input  logic [ValueW-1:0]   start_value,
	// result items
	output logic                out_valid,
	input  logic                out_stall,
	output logic                keep_going,
	output logic                accept_phase,
	output logic                agreed,
	output logic [SerialW-1:0]  cur_serial,
	output logic [ValueW-1:0]   cur_value,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	cfg_t   cfg_q;
	item_t  item_s1;
	logic   valid_s1;
	round_t round_q;
	round_t round_nxt;
	logic   going;
	logic   advance;
	logic   in_take;
	logic   out_valid_q;

	// APB registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_ACCEPTOR_COUNT) begin
				cfg_q.acceptor_count <= pwdata[CfgW-1:0];
			end else begin
				cfg_q.proposer_count <= pwdata[CfgW-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_PROPOSER_COUNT)
	                ? {{(ApbDataW-CfgW){1'b0}}, cfg_q.proposer_count}
	                : {{(ApbDataW-CfgW){1'b0}}, cfg_q.acceptor_count};

	// Handshake: the input register moves on when the result slot is free or not stalled
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode       <= opcode;
			item_s1.ok           <= ok;
			item_s1.reply_serial <= reply_serial;
			item_s1.reply_value  <= reply_value;
			item_s1.start_serial <= start_serial;
			item_s1.start_value  <= start_value;
		end
	end

	pxp_round_update u_update (
		.cur   (round_q),
		.cfg   (cfg_q),
		.item  (item_s1),
		.nxt   (round_nxt),
		.going (going)
	);

	// Commit round state as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (valid_s1 && advance) begin
			round_q <= round_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			keep_going   <= going;
			accept_phase <= round_nxt.phase_done;
			agreed       <= round_nxt.agree_flag;
			cur_serial   <= round_nxt.prop_serial;
			cur_value    <= round_nxt.prop_value;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/pxp_checker.sv @@
// Port-level checks for the Paxos proposer vote tracker, bound to the top level.
// Depends on pxp_pkg.
module pxp_checker import pxp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               keep_going,
	input logic               accept_phase,
	input logic               agreed,
	input logic [SerialW-1:0] cur_serial
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cur_serial))
		else $error("stalled result changed");

	// An empty result slot never stalls the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result slot");

	// A restart clears both phase flags
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !keep_going |-> !accept_phase && !agreed)
		else $error("restart result shows phase flags");

	// Agreement only in phase 2
	a_agree_phase2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && agreed |-> accept_phase)
		else $error("agreed outside phase 2");

endmodule

bind paxos_proposer_vote_tracker pxp_checker u_pxp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.keep_going   (keep_going),
	.accept_phase (accept_phase),
	.agreed       (agreed),
	.cur_serial   (cur_serial)
);
